// File: src/lfu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU replacement package
// Shared sizes, types and the helper function of the LFU page replacement unit.
// ----------------------------------------------------------------------------
package lfu_pkg;

	// Design sizes.
	localparam int FRAMES     = 8;
	localparam int PAGE_BITS  = 8;
	localparam int COUNT_BITS = 16;

	// Fixed widths of the channel fields.
	localparam int PAGE_W      = 8;
	localparam int IDX_OUT_W   = 3;
	localparam int CFG_W       = 4;

	// Derived widths.
	localparam int IDX_W      = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int ACT_W      = $clog2(FRAMES + 1);
	localparam int PAGE_COUNT = 1 << PAGE_BITS;

	typedef logic [PAGE_BITS-1:0]  page_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [ACT_W-1:0]      act_t;

	// Search token that walks the frame chain, one cell per cycle.
	typedef struct packed {
		logic   vld;
		page_t  page;
		logic   hit;
		idx_t   hit_idx;
		logic   emp;
		idx_t   emp_idx;
		logic   best;
		idx_t   best_idx;
		count_t best_freq;
		count_t best_uses;
		page_t  best_page;
	} lfu_tok_t;

	// Update of one frame at the end of a request.
	typedef struct packed {
		logic   en;
		page_t  page;
		count_t freq;
	} lfu_wr_t;

	// Control sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} lfu_state_t;

	// Saturating increment of a counter.
	function automatic count_t sat_inc(count_t v);
		return (v == '1) ? v : v + COUNT_BITS'(1);
	endfunction

endpackage

// File: src/lfu_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU channel interfaces
// Valid/ready channels for page requests, responses and the frame count write.
// ----------------------------------------------------------------------------

// Page reference request channel.
interface lfu_req_if;
	logic                        valid;
	logic                        ready;
	logic [lfu_pkg::PAGE_W-1:0]  page;

	modport source (output valid, output page, input ready);
	modport sink   (input valid, input page, output ready);
endinterface

// Replacement response channel.
interface lfu_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic [lfu_pkg::IDX_OUT_W-1:0] frame_index;
	logic                          evicted_valid;
	logic [lfu_pkg::PAGE_W-1:0]    evicted_page;

	modport source (output valid, output hit, output frame_index, output evicted_valid,
		output evicted_page, input ready);
	modport sink   (input valid, input hit, input frame_index, input evicted_valid,
		input evicted_page, output ready);
endinterface

// Frame count register write channel.
interface lfu_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [lfu_pkg::CFG_W-1:0]  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: src/lfu_page_replacement_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU page replacement unit
// Least-frequently-used page frame replacement over a chain of frame cells.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one page reference per request; rsp returns one result per
//   request: hit flag, frame that holds the page, and the evicted page if a
//   resident page was replaced. cfg writes the number of frames in use
//   (0 acts as 1, values above the frame count act as the frame count); it is
//   always ready. The user must write it only while no request is in flight;
//   the block does not enforce this. One request is processed at a time:
//   a search token walks the frame chain one cell per cycle, and a new
//   request is accepted only after the sequencer has committed the previous
//   result and returned to idle.
//   The reference count table is read at acceptance and written when the
//   result is committed.
//   If the receiver stalls, the result waits in the output register and the
//   next request may still be accepted and searched; its commit waits until
//   the output register is free.
//   Reset empties all frames, clears use counts and marks every entry of the
//   reference count table as zero through per-entry valid bits; no clearing
//   pass is needed.
// ----------------------------------------------------------------------------
module lfu_page_replacement_unit (
	input  logic      clk,
	input  logic      arst_n,
	lfu_cfg_if.sink   cfg,
	lfu_req_if.sink   req,
	lfu_rsp_if.source rsp
);

	lfu_pkg::lfu_state_t state_q;
	lfu_pkg::lfu_state_t state_n;

	lfu_pkg::act_t     act_q;
	lfu_pkg::lfu_tok_t inj_n;
	lfu_pkg::lfu_tok_t inj_q;
	lfu_pkg::lfu_tok_t done_q;
	lfu_pkg::lfu_tok_t chain [lfu_pkg::FRAMES+1];
	lfu_pkg::lfu_wr_t  wr    [lfu_pkg::FRAMES];
	logic              active [lfu_pkg::FRAMES];

	lfu_pkg::page_t    addr_q;
	lfu_pkg::count_t   cnt_mem [lfu_pkg::PAGE_COUNT];
	logic [lfu_pkg::PAGE_COUNT-1:0] cnt_vld_q;
	lfu_pkg::count_t   rd_q;
	logic              rd_vld_q;

	logic              req_acc;
	logic              commit;
	lfu_pkg::page_t    req_addr;
	lfu_pkg::idx_t     slot;
	logic              evict;
	lfu_pkg::count_t   cnt;

	logic                              rsp_valid_q;
	logic                              rsp_hit_q;
	logic [lfu_pkg::IDX_OUT_W-1:0]     rsp_idx_q;
	logic                              rsp_ev_q;
	logic [lfu_pkg::PAGE_W-1:0]        rsp_evp_q;

	assign req_addr = lfu_pkg::PAGE_BITS'(req.page);

	// Frame count register, clamped into range when written.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= lfu_pkg::ACT_W'(lfu_pkg::FRAMES);
		end else if (cfg.valid) begin
			priority if (cfg.data == '0) begin
				act_q <= lfu_pkg::ACT_W'(1);
			end else if (32'(cfg.data) > 32'(lfu_pkg::FRAMES)) begin
				act_q <= lfu_pkg::ACT_W'(lfu_pkg::FRAMES);
			end else begin
				act_q <= lfu_pkg::ACT_W'(cfg.data);
			end
		end
	end

	// Next state of the request sequencer.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			lfu_pkg::ST_IDLE: begin
				if (req.valid) begin
					state_n = lfu_pkg::ST_SCAN;
				end
			end
			lfu_pkg::ST_SCAN: begin
				if (chain[lfu_pkg::FRAMES].vld) begin
					state_n = lfu_pkg::ST_COMMIT;
				end
			end
			lfu_pkg::ST_COMMIT: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_n = lfu_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = lfu_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		req.ready = 1'b0;
		commit    = 1'b0;
		unique case (state_q)
			lfu_pkg::ST_IDLE: begin
				req.ready = 1'b1;
			end
			lfu_pkg::ST_SCAN: begin
			end
			lfu_pkg::ST_COMMIT: begin
				commit = !rsp_valid_q || rsp.ready;
			end
			default: begin
			end
		endcase
	end

	assign req_acc = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfu_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Build the search token for a newly accepted request.
	always_comb begin
		inj_n      = '0;
		inj_n.vld  = req_acc;
		inj_n.page = req_addr;
	end

	// Launch the search token into the first cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inj_q <= '0;
		end else begin
			inj_q <= inj_n;
		end
	end

	assign chain[0] = inj_q;

	// Row of frame cells.
	for (genvar i = 0; i < lfu_pkg::FRAMES; i++) begin : g_cell
		assign active[i]  = 32'(i) < 32'(act_q);
		assign wr[i].en   = commit && (slot == lfu_pkg::IDX_W'(i));
		assign wr[i].page = done_q.page;
		assign wr[i].freq = cnt;

		lfu_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (lfu_pkg::IDX_W'(i)),
			.active   (active[i]),
			.tok_i    (chain[i]),
			.wr       (wr[i]),
			.tok_o    (chain[i+1])
		);
	end

	// Capture the finished token until the result can be committed.
	always_ff @(posedge clk) begin
		if (chain[lfu_pkg::FRAMES].vld) begin
			done_q <= chain[lfu_pkg::FRAMES];
		end
	end

	// Reference count table: read at acceptance, written at commit.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			rd_q   <= cnt_mem[req_addr];
			addr_q <= req_addr;
		end
		if (commit) begin
			cnt_mem[addr_q] <= cnt;
		end
	end

	// Per-entry valid bits; an entry never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (req_acc) begin
				rd_vld_q <= cnt_vld_q[req_addr];
			end
			if (commit) begin
				cnt_vld_q[addr_q] <= 1'b1;
			end
		end
	end

	// Victim choice: hit frame, else first empty frame, else lowest reference count, fewest uses breaking ties.
	always_comb begin
		evict = 1'b0;
		priority if (done_q.hit) begin
			slot = done_q.hit_idx;
		end else if (done_q.emp) begin
			slot = done_q.emp_idx;
		end else begin
			slot  = done_q.best_idx;
			evict = 1'b1;
		end
	end

	assign cnt = lfu_pkg::sat_inc(rd_vld_q ? rd_q : '0);

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_hit_q <= done_q.hit;
			rsp_idx_q <= lfu_pkg::IDX_OUT_W'(slot);
			rsp_ev_q  <= evict;
			rsp_evp_q <= evict ? lfu_pkg::PAGE_W'(done_q.best_page) : '0;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.hit           = rsp_hit_q;
	assign rsp.frame_index   = rsp_idx_q;
	assign rsp.evicted_valid = rsp_ev_q;
	assign rsp.evicted_page  = rsp_evp_q;

endmodule

// File: src/lfu_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU frame cell
// Holds one page frame, folds it into the passing search token and takes
// the frame update at the end of a request.
// ----------------------------------------------------------------------------
module lfu_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  lfu_pkg::idx_t     cell_idx,
	input  logic              active,
	input  lfu_pkg::lfu_tok_t tok_i,
	input  lfu_pkg::lfu_wr_t  wr,
	output lfu_pkg::lfu_tok_t tok_o
);

	lfu_pkg::page_t    page_q;
	logic              valid_q;
	lfu_pkg::count_t   freq_q;
	lfu_pkg::count_t   uses_q;
	lfu_pkg::lfu_tok_t tok_n;
	lfu_pkg::lfu_tok_t tok_q;

	// Fold this frame into the token: first hit, first empty frame, lowest reference count, fewest uses.
	always_comb begin
		tok_n = tok_i;
		if (tok_i.vld && active) begin
			if (valid_q && (page_q == tok_i.page) && !tok_i.hit) begin
				tok_n.hit     = 1'b1;
				tok_n.hit_idx = cell_idx;
			end
			if (!valid_q && !tok_i.emp) begin
				tok_n.emp     = 1'b1;
				tok_n.emp_idx = cell_idx;
			end
			if (valid_q && (!tok_i.best || (freq_q < tok_i.best_freq) ||
					((freq_q == tok_i.best_freq) && (uses_q < tok_i.best_uses)))) begin
				tok_n.best      = 1'b1;
				tok_n.best_idx  = cell_idx;
				tok_n.best_freq = freq_q;
				tok_n.best_uses = uses_q;
				tok_n.best_page = page_q;
			end
		end
	end

	// Hand the token to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_n;
		end
	end

	assign tok_o = tok_q;

	// Frame contents; the use count is never cleared after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q  <= '0;
			valid_q <= 1'b0;
			freq_q  <= '0;
			uses_q  <= '0;
		end else if (wr.en) begin
			page_q  <= wr.page;
			valid_q <= 1'b1;
			freq_q  <= wr.freq;
			uses_q  <= lfu_pkg::sat_inc(uses_q);
		end
	end

endmodule

// File: src/lfu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU port checker
// Checks response consistency and request pacing on the top-level ports.
// ----------------------------------------------------------------------------
module lfu_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic                          hit,
	input logic [lfu_pkg::IDX_OUT_W-1:0] frame_index,
	input logic                          evicted_valid,
	input logic [lfu_pkg::PAGE_W-1:0]    evicted_page
);

	// A hit never evicts a page.
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(hit && evicted_valid))
		else $error("hit response reports an eviction");

	// Without an eviction the evicted page reads zero.
	a_no_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !evicted_valid) |-> (evicted_page == '0))
		else $error("evicted page nonzero without eviction");

	// The reported frame lies within the frame row.
	a_frame_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (32'(frame_index) < 32'(lfu_pkg::FRAMES)))
		else $error("frame index out of range");

	// After a request is accepted the unit is busy for the next cycle.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted in back-to-back cycles");

	// A stalled response holds its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(hit) &&
			$stable(frame_index) && $stable(evicted_valid) && $stable(evicted_page)))
		else $error("stalled response changed");

endmodule

bind lfu_page_replacement_unit lfu_checker u_lfu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.hit           (rsp.hit),
	.frame_index   (rsp.frame_index),
	.evicted_valid (rsp.evicted_valid),
	.evicted_page  (rsp.evicted_page)
);

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU page replacement unit testbench
// Drives page references and frame count writes with random gaps and
// back-pressure. A tracker keeps its own copy of the frames, the use counts
// and the reference count table, predicts each response and compares every
// field in order.
// ----------------------------------------------------------------------------
module tb;

	localparam int STALL_LIMIT = 1000;

	// One expected or observed response.
	typedef struct {
		logic                          hit;
		logic [lfu_pkg::IDX_OUT_W-1:0] frame_index;
		logic                          evicted_valid;
		logic [lfu_pkg::PAGE_W-1:0]    evicted_page;
	} lfu_result_t;

	// Frame table tracker: predicts the replacement decision for every accepted
	// request and checks responses against the oldest prediction.
	class lfu_replacement_tracker;
		lfu_pkg::page_t            held_page[lfu_pkg::FRAMES];
		logic                      resident[lfu_pkg::FRAMES];
		lfu_pkg::count_t           held_count[lfu_pkg::FRAMES];
		lfu_pkg::count_t           serve_count[lfu_pkg::FRAMES];
		lfu_pkg::count_t           page_refs[lfu_pkg::PAGE_COUNT];
		logic [lfu_pkg::CFG_W-1:0] frames_cfg;
		lfu_result_t               expected_responses[$];
		int                        mismatch_count;

		function new();
			foreach (held_page[f]) begin
				held_page[f]   = '0;
				resident[f]    = 1'b0;
				held_count[f]  = '0;
				serve_count[f] = '0;
			end
			foreach (page_refs[p])
				page_refs[p] = '0;
			frames_cfg     = lfu_pkg::CFG_W'(lfu_pkg::FRAMES);
			mismatch_count = 0;
		endfunction

		function void set_frames(logic [lfu_pkg::CFG_W-1:0] v);
			frames_cfg = v;
		endfunction

		function int pending();
			return expected_responses.size();
		endfunction

		// Counters stick at their maximum.
		function lfu_pkg::count_t bump(lfu_pkg::count_t v);
			return (&v) ? v : v + lfu_pkg::count_t'(1);
		endfunction

		task flag_mismatch(string what, int got, int want);
			$display("%0t: mismatch in %s: got %0h, want %0h", $time, what, got, want);
			mismatch_count++;
		endtask

		// Work out the replacement for one accepted page reference.
		task note_reference(logic [lfu_pkg::PAGE_W-1:0] raw);
			lfu_pkg::page_t  pg;
			int              act;
			int              slot;
			bit              found;
			lfu_pkg::count_t best_freq;
			lfu_pkg::count_t best_uses;
			lfu_pkg::count_t cnt;
			lfu_result_t     r;
			pg = lfu_pkg::page_t'(raw);
			act = (frames_cfg == 0) ? 1 :
				((frames_cfg > lfu_pkg::FRAMES) ? lfu_pkg::FRAMES : int'(frames_cfg));
			r.hit = 1'b0;
			r.evicted_valid = 1'b0;
			r.evicted_page = '0;
			found = 1'b0;
			slot = 0;
			// Search the active frames for a hit first.
			for (int f = 0; f < act && !found; f++) begin
				if (resident[f] && held_page[f] == pg) begin
					slot = f;
					found = 1'b1;
					r.hit = 1'b1;
				end
			end
			// Then the lowest empty active frame.
			for (int f = 0; f < act && !found; f++) begin
				if (!resident[f]) begin
					slot = f;
					found = 1'b1;
				end
			end
			// Otherwise evict the least referenced page, fewest uses breaking ties.
			if (!found) begin
				best_freq = held_count[0];
				best_uses = serve_count[0];
				for (int f = 1; f < act; f++) begin
					if (held_count[f] < best_freq ||
						(held_count[f] == best_freq && serve_count[f] < best_uses)) begin
						best_freq = held_count[f];
						best_uses = serve_count[f];
						slot = f;
					end
				end
				r.evicted_valid = 1'b1;
				r.evicted_page = lfu_pkg::PAGE_W'(held_page[slot]);
			end
			cnt = bump(page_refs[pg]);
			page_refs[pg] = cnt;
			held_page[slot] = pg;
			resident[slot] = 1'b1;
			held_count[slot] = cnt;
			serve_count[slot] = bump(serve_count[slot]);
			r.frame_index = lfu_pkg::IDX_OUT_W'(slot);
			expected_responses.push_back(r);
		endtask

		// Compare one response with the oldest prediction.
		task check_response(lfu_result_t got);
			lfu_result_t want;
			if (expected_responses.size() == 0) begin
				flag_mismatch("unexpected response", 1, 0);
			end else begin
				want = expected_responses.pop_front();
				if (got.hit !== want.hit)
					flag_mismatch("hit", got.hit, want.hit);
				if (got.frame_index !== want.frame_index)
					flag_mismatch("frame_index", got.frame_index, want.frame_index);
				if (got.evicted_valid !== want.evicted_valid)
					flag_mismatch("evicted_valid", got.evicted_valid, want.evicted_valid);
				if (got.evicted_page !== want.evicted_page)
					flag_mismatch("evicted_page", got.evicted_page, want.evicted_page);
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   calm = 1'b0;
	int   idle_cycles = 0;

	lfu_replacement_tracker tracker = new();

	lfu_cfg_if cfg_ch();
	lfu_req_if req_ch();
	lfu_rsp_if rsp_ch();

	lfu_page_replacement_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #5 clk = ~clk;

	// Offer one page reference after a random gap and hold it until accepted.
	task send_page(input logic [lfu_pkg::PAGE_W-1:0] pg);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.page  <= pg;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Stop sending and wait until every predicted response has arrived.
	task wait_drained();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
	endtask

	// Change the frame count once the unit has gone idle.
	task write_frames(input logic [lfu_pkg::CFG_W-1:0] v);
		wait_drained();
		repeat (lfu_pkg::FRAMES + 4) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// Receiver with random stalls before each response.
	initial begin
		int stall;
		forever begin
			stall = calm ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	// Observe accepted requests, responses and writes; watch for a hang.
	always @(posedge clk) begin : observe
		lfu_result_t got;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.hit = rsp_ch.hit;
				got.frame_index = rsp_ch.frame_index;
				got.evicted_valid = rsp_ch.evicted_valid;
				got.evicted_page = rsp_ch.evicted_page;
				tracker.check_response(got);
			end
			if (req_ch.valid && req_ch.ready)
				tracker.note_reference(req_ch.page);
			if (cfg_ch.valid && cfg_ch.ready)
				tracker.set_frames(cfg_ch.data);
		end
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Stimulus.
	initial begin
		logic [lfu_pkg::PAGE_W-1:0] directed_pages[$];
		int                         frame_settings[$];
		int                         ws;
		int                         base;
		logic [lfu_pkg::PAGE_W-1:0] pg;
		arst_n       <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.page  <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill all eight frames, hit some, then force evictions.
		directed_pages = '{8'h00, 8'hff, 8'haa, 8'h55, 8'h01, 8'h02, 8'h03, 8'h04,
			8'hff, 8'h00, 8'haa, 8'hc8, 8'hc8, 8'h07, 8'h02};
		foreach (directed_pages[i])
			send_page(directed_pages[i]);

		// A frame count of zero acts as one frame; frame 1 is out of range.
		write_frames(4'd0);
		send_page(8'h09);
		send_page(8'h09);
		send_page(8'hff);

		// An oversized count acts as all frames; the parked frames come back.
		write_frames(4'd15);
		send_page(8'hff);
		send_page(8'h03);
		send_page(8'h80);
		wait_drained();

		// Random phases: mostly a small working set so that hits and LFU ties
		// are frequent, with some references anywhere in the page space.
		frame_settings = '{3, 8, 1, 5, 12, 2, 7, 4, 9, 6, 8, 0, 15};
		foreach (frame_settings[i]) begin
			write_frames(lfu_pkg::CFG_W'(frame_settings[i]));
			calm = ($urandom_range(0, 3) == 0);
			ws = $urandom_range(1, 14);
			base = $urandom_range(0, 255 - ws);
			repeat (85) begin
				if ($urandom_range(0, 4) == 0)
					pg = lfu_pkg::PAGE_W'($urandom_range(0, 255));
				else
					pg = lfu_pkg::PAGE_W'(base + $urandom_range(0, ws));
				send_page(pg);
				if ($urandom_range(0, 59) == 0)
					wait_drained();
			end
		end

		wait_drained();
		repeat (lfu_pkg::FRAMES + 6) @(posedge clk);
		if (tracker.mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
